### hdl/hdt_pkg.sv
// ----------------------------------------------------------------------------
// hdt_pkg
// Shared types and constants of the huffman tree byte decoder.
// ----------------------------------------------------------------------------
package hdt_pkg;

  localparam int LEN_W      = 24;
  localparam int NODE_W     = 8;
  localparam int CHILD_W    = 9;
  localparam int SYM_W      = 8;
  localparam int BYTE_BITS  = 8;
  localparam int OP_W       = 2;

  localparam logic [CHILD_W-1:0] CHILD_MAX     = 9'd510;
  localparam logic [CHILD_W-1:0] LITERAL_LIMIT = 9'd256;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int TREE_NODES_DEF  = 255;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_BYTE
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [NODE_W-1:0]  node_index;
    logic [CHILD_W-1:0] child_zero;
    logic [CHILD_W-1:0] child_one;
    logic               load_error;
    logic [LEN_W-1:0]   chunk_length;
    logic [SYM_W-1:0]   data_byte;
  } cmd_t;

  function automatic logic [CHILD_W-1:0] clamp_child(input logic [CHILD_W-1:0] c);
    clamp_child = (c > CHILD_MAX) ? CHILD_MAX : c;
  endfunction

endpackage

### hdl/hdt_if.sv
// ----------------------------------------------------------------------------
// hdt_if
// Valid/ready channels of the decoder: command input and symbol output.
// ----------------------------------------------------------------------------
interface hdt_in_if;
  logic                          valid;
  logic                          ready;
  logic [hdt_pkg::OP_W-1:0]      op;
  logic [hdt_pkg::NODE_W-1:0]    node_index;
  logic [hdt_pkg::CHILD_W-1:0]   child_zero;
  logic [hdt_pkg::CHILD_W-1:0]   child_one;
  logic [hdt_pkg::LEN_W-1:0]     chunk_length;
  logic [hdt_pkg::SYM_W-1:0]     data_byte;

  modport source (output valid, op, node_index, child_zero, child_one, chunk_length,
                  data_byte, input ready);
  modport sink   (input valid, op, node_index, child_zero, child_one, chunk_length,
                  data_byte, output ready);
endinterface

interface hdt_out_if;
  logic                       valid;
  logic                       ready;
  logic [hdt_pkg::SYM_W-1:0]  symbol;
  logic                       chunk_done;
  logic                       run_last;
  logic                       load_error;

  modport source (output valid, symbol, chunk_done, run_last, load_error, input ready);
  modport sink   (input valid, symbol, chunk_done, run_last, load_error, output ready);
endinterface

### hdl/hdt_ram.sv
// ----------------------------------------------------------------------------
// hdt_ram
// Generic simple dual port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hdt_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 255,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/hdt_front.sv
// ----------------------------------------------------------------------------
// hdt_front
// Accepts input transactions, classifies the op and clamps node children.
// ----------------------------------------------------------------------------
module hdt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  hdt_in_if.sink        in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output hdt_pkg::cmd_t cmd_o
);

  hdt_pkg::cmd_t cmd_d;
  hdt_pkg::cmd_t cmd_q;
  logic          keep;
  logic          slot_valid_q;
  logic          accept;

  always_comb begin
    cmd_d              = '0;
    keep               = 1'b1;
    cmd_d.node_index   = in_i.node_index;
    cmd_d.child_zero   = hdt_pkg::clamp_child(in_i.child_zero);
    cmd_d.child_one    = hdt_pkg::clamp_child(in_i.child_one);
    cmd_d.load_error   = (in_i.child_zero > hdt_pkg::CHILD_MAX) ||
                         (in_i.child_one > hdt_pkg::CHILD_MAX);
    cmd_d.chunk_length = in_i.chunk_length;
    cmd_d.data_byte    = in_i.data_byte;
    case (in_i.op)
      hdt_pkg::OP_LOAD:  cmd_d.kind = hdt_pkg::CMD_LOAD;
      hdt_pkg::OP_START: cmd_d.kind = hdt_pkg::CMD_START;
      hdt_pkg::OP_DATA:  cmd_d.kind = hdt_pkg::CMD_BYTE;
      default: begin
        cmd_d.kind = hdt_pkg::CMD_BYTE;
        keep       = 1'b0;
      end
    endcase
  end

  assign in_i.ready = !slot_valid_q || cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else if (accept) begin
      slot_valid_q <= keep;
    end else if (cmd_ready_i) begin
      slot_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = slot_valid_q;
  assign cmd_o       = cmd_q;

endmodule

### hdl/hdt_fifo.sv
// ----------------------------------------------------------------------------
// hdt_fifo
// Short command queue between the front and the tree walker.
// ----------------------------------------------------------------------------
module hdt_fifo #(
  parameter int DEPTH = hdt_pkg::QUEUE_DEPTH_DEF,
  localparam int PW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  hdt_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output hdt_pkg::cmd_t pop_data_o
);

  hdt_pkg::cmd_t entry_q [DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [PW:0]   count_q;
  logic          do_push;
  logic          do_pop;

  assign push_ready_o = (count_q != (PW+1)'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/hdt_back.sv
// ----------------------------------------------------------------------------
// hdt_back
// Executes queued commands: node loads, chunk starts and bit serial tree walks.
// ----------------------------------------------------------------------------
module hdt_back #(
  parameter int LENGTH_BITS = hdt_pkg::LENGTH_BITS_DEF,
  parameter int TREE_NODES  = hdt_pkg::TREE_NODES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  hdt_pkg::cmd_t cmd_i,
  hdt_out_if.source     out_o
);

  localparam int AW     = $clog2(TREE_NODES);
  localparam int NODE_W = hdt_pkg::NODE_W;
  localparam int CW     = hdt_pkg::CHILD_W;
  localparam int BW     = $clog2(hdt_pkg::BYTE_BITS);
  localparam logic [NODE_W-1:0] HEAD = NODE_W'(TREE_NODES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e                   state_q;
  logic [LENGTH_BITS-1:0]   remaining_q;
  logic [NODE_W-1:0]        cur_node_q;
  logic                     node_ok_q;
  logic [hdt_pkg::SYM_W-1:0] byte_q;
  logic [BW-1:0]            bit_cnt_q;
  logic                     pend_valid_q;
  logic [hdt_pkg::SYM_W-1:0] pend_sym_q;
  logic                     pend_done_q;

  logic                     out_valid_q;
  logic [hdt_pkg::SYM_W-1:0] out_sym_q;
  logic                     out_done_q;
  logic                     out_last_q;
  logic                     out_err_q;

  logic [LENGTH_BITS-1:0]   len_sat;
  logic [2*CW-1:0]          rdata;
  logic [2*CW-1:0]          kids;
  logic [CW-1:0]            branch;
  logic                     cur_bit;
  logic                     is_lit;
  logic [NODE_W-1:0]        next_node;
  logic                     can_push;
  logic                     walk_go;
  logic                     walk_last;
  logic                     pop;
  logic                     idx_ok;
  logic                     we;
  logic [AW-1:0]            raddr;

  logic                     push;
  logic [hdt_pkg::SYM_W-1:0] push_sym;
  logic                     push_done;
  logic                     push_last;
  logic                     push_err;

  if (LENGTH_BITS >= hdt_pkg::LEN_W) begin : g_len_wide
    assign len_sat = LENGTH_BITS'(cmd_i.chunk_length);
  end else begin : g_len_narrow
    assign len_sat = (|cmd_i.chunk_length[hdt_pkg::LEN_W-1:LENGTH_BITS]) ? '1
                   : cmd_i.chunk_length[LENGTH_BITS-1:0];
  end

  assign can_push    = !out_valid_q || out_o.ready;
  assign cmd_ready_o = (state_q == ST_IDLE) &&
                       ((cmd_i.kind != hdt_pkg::CMD_LOAD) || can_push);
  assign idx_ok = ({1'b0, cmd_i.node_index} < (NODE_W+1)'(TREE_NODES));
  assign pop    = cmd_valid_i && cmd_ready_o;
  assign we     = pop && (cmd_i.kind == hdt_pkg::CMD_LOAD) && idx_ok;

  hdt_ram #(
    .WIDTH (2*CW),
    .DEPTH (TREE_NODES)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cmd_i.node_index[AW-1:0]),
    .wdata_i ({cmd_i.child_one, cmd_i.child_zero}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    cur_bit   = byte_q[bit_cnt_q];
    kids      = node_ok_q ? rdata : '0;
    branch    = cur_bit ? kids[2*CW-1:CW] : kids[CW-1:0];
    is_lit    = (branch < hdt_pkg::LITERAL_LIMIT);
    next_node = is_lit ? HEAD : branch[NODE_W-1:0];
    walk_go   = (state_q == ST_WALK) && (!(is_lit && pend_valid_q) || can_push);
    walk_last = (bit_cnt_q == BW'(hdt_pkg::BYTE_BITS - 1)) ||
                (is_lit && (remaining_q == LENGTH_BITS'(1)));
    raddr     = walk_go ? next_node[AW-1:0] : cur_node_q[AW-1:0];

    push      = 1'b0;
    push_sym  = pend_sym_q;
    push_done = pend_done_q;
    push_last = 1'b0;
    push_err  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop && (cmd_i.kind == hdt_pkg::CMD_LOAD)) begin
          push      = 1'b1;
          push_sym  = '0;
          push_done = 1'b0;
          push_err  = cmd_i.load_error;
        end
      end
      ST_WALK: begin
        push = walk_go && is_lit && pend_valid_q;
      end
      ST_FLUSH: begin
        push      = can_push;
        push_last = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      remaining_q  <= '0;
      cur_node_q   <= HEAD;
      node_ok_q    <= 1'b1;
      bit_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            case (cmd_i.kind)
              hdt_pkg::CMD_START: begin
                remaining_q <= len_sat;
                cur_node_q  <= HEAD;
                node_ok_q   <= 1'b1;
              end
              hdt_pkg::CMD_BYTE: begin
                if (remaining_q != '0) begin
                  bit_cnt_q <= '0;
                  state_q   <= ST_READ;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_READ: state_q <= ST_WALK;
        ST_WALK: begin
          if (walk_go) begin
            cur_node_q <= next_node;
            node_ok_q  <= ({1'b0, next_node} < (NODE_W+1)'(TREE_NODES));
            bit_cnt_q  <= bit_cnt_q + 1'b1;
            if (is_lit) begin
              remaining_q  <= remaining_q - 1'b1;
              pend_valid_q <= 1'b1;
            end
            if (walk_last) begin
              state_q <= (pend_valid_q || is_lit) ? ST_FLUSH : ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (can_push) begin
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (cmd_i.kind == hdt_pkg::CMD_BYTE)) begin
      byte_q <= cmd_i.data_byte;
    end
    if (walk_go && is_lit) begin
      pend_sym_q  <= branch[hdt_pkg::SYM_W-1:0];
      pend_done_q <= (remaining_q == LENGTH_BITS'(1));
    end
    if (push) begin
      out_sym_q  <= push_sym;
      out_done_q <= push_done;
      out_last_q <= push_last;
      out_err_q  <= push_err;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.symbol     = out_sym_q;
  assign out_o.chunk_done = out_done_q;
  assign out_o.run_last   = out_last_q;
  assign out_o.load_error = out_err_q;

  a_pend_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q == ST_WALK || state_q == ST_FLUSH))
    else $error("pending symbol outside a byte walk");

  a_flush_has_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> pend_valid_q)
    else $error("flush without a pending symbol");

  a_read_first_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (bit_cnt_q == '0 && !pend_valid_q))
    else $error("byte walk not starting at bit zero");

  a_walk_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (remaining_q != '0))
    else $error("walking with no chunk length left");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !cmd_ready_o)
    else $error("command taken during a walk");

endmodule

### hdl/huffman_tree_byte_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_byte_decoder
// Huffman decoder walking a stored binary tree, one compressed bit a cycle unless a full output stalls it.
// ----------------------------------------------------------------------------
// channel  dir  payload                                             transaction
// in_i     in   op, node_index, child_zero, child_one,              valid & ready
//               chunk_length, data_byte
// out_o    out  symbol, chunk_done, run_last, load_error            valid & ready
//
// a node load or a chunk start is taken by the walker in its idle state
// a data byte passes a read state, walks up to 8 bits, then a flush state, if a
// symbol is pending, releases the last symbol of the byte; the single tree ram read port sets this
// a full output register stalls the walker; the queue keeps the input open
// reset clears control state only; tree contents are undefined until loaded
// ----------------------------------------------------------------------------
module huffman_tree_byte_decoder #(
  parameter int LENGTH_BITS = hdt_pkg::LENGTH_BITS_DEF,
  parameter int TREE_NODES  = hdt_pkg::TREE_NODES_DEF,
  parameter int QUEUE_DEPTH = hdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hdt_in_if.sink    in_i,
  hdt_out_if.source out_o
);

  logic          front_valid;
  logic          front_ready;
  hdt_pkg::cmd_t front_cmd;
  logic          back_valid;
  logic          back_ready;
  hdt_pkg::cmd_t back_cmd;

  hdt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  hdt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  hdt_back #(
    .LENGTH_BITS (LENGTH_BITS),
    .TREE_NODES  (TREE_NODES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_o       (out_o)
  );

endmodule

### tb/tb_huffman_tree_byte_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_tree_byte_decoder
// Self-checking bench for the huffman tree byte decoder. Loads decoding
// trees, starts chunks and feeds compressed bytes over the command channel,
// predicts every decoded symbol and load response, and checks each symbol
// transaction in order. Traffic runs under random sender and receiver gaps,
// a long receiver hold-off and sender pauses until all symbols have drained.
// ----------------------------------------------------------------------------

localparam int               HEAD_NODE   = hdt_pkg::TREE_NODES_DEF - 1;
localparam logic [1:0]       OP_RESERVED = 2'd3;
localparam logic [7:0]       NODE_VOID   = 8'd255;
localparam logic [8:0]       CHILD_OVER  = 9'd511;

typedef struct packed {
  logic [1:0]  op;
  logic [7:0]  node_index;
  logic [8:0]  child_zero;
  logic [8:0]  child_one;
  logic [23:0] chunk_length;
  logic [7:0]  data_byte;
} command_t;

typedef struct packed {
  logic [7:0] symbol;
  logic       chunk_done;
  logic       run_last;
  logic       load_error;
} symbol_t;

class symbol_predictor;
  logic [8:0]  zero_kid [hdt_pkg::TREE_NODES_DEF];
  bit          written  [hdt_pkg::TREE_NODES_DEF];
  logic [8:0]  one_kid  [hdt_pkg::TREE_NODES_DEF];
  logic [7:0]  cur_node;
  logic [23:0] bytes_left;
  symbol_t     pending_symbols[$];
  int          failures;

  function new();
    foreach (written[i]) begin
      written[i]  = 1'b0;
      zero_kid[i] = '0;
      one_kid[i]  = '0;
    end
    cur_node   = 8'(HEAD_NODE);
    bytes_left = '0;
    failures   = 0;
  endfunction

  function logic [8:0] branch_of(logic [7:0] node, logic b);
    if (node >= hdt_pkg::TREE_NODES_DEF) return '0;
    return b ? one_kid[node] : zero_kid[node];
  endfunction

  // true when walking this byte reads only loaded nodes
  function bit byte_is_safe(logic [7:0] data);
    logic [7:0]  node = cur_node;
    logic [23:0] left = bytes_left;
    logic [8:0]  br;
    for (int k = 0; k < 8 && left != 0; k++) begin
      if (node < hdt_pkg::TREE_NODES_DEF && !written[node]) return 1'b0;
      br = branch_of(node, data[k]);
      if (br < hdt_pkg::LITERAL_LIMIT) begin
        left--;
        node = 8'(HEAD_NODE);
      end else begin
        node = br[7:0];
      end
    end
    return 1'b1;
  endfunction

  // returns 1 when the transaction is not ignored by the decoder
  function bit note_command(command_t c);
    symbol_t    run[8];
    int         n = 0;
    logic [8:0] k0, k1, br;
    case (c.op)
      hdt_pkg::OP_LOAD: begin
        k0 = (c.child_zero > hdt_pkg::CHILD_MAX) ? hdt_pkg::CHILD_MAX : c.child_zero;
        k1 = (c.child_one > hdt_pkg::CHILD_MAX) ? hdt_pkg::CHILD_MAX : c.child_one;
        if (c.node_index < hdt_pkg::TREE_NODES_DEF) begin
          zero_kid[c.node_index] = k0;
          one_kid[c.node_index]  = k1;
          written[c.node_index]  = 1'b1;
        end
        pending_symbols.push_back('{8'd0, 1'b0, 1'b0,
          (c.child_zero > hdt_pkg::CHILD_MAX) || (c.child_one > hdt_pkg::CHILD_MAX)});
        return 1'b1;
      end
      hdt_pkg::OP_START: begin
        bytes_left = c.chunk_length;
        cur_node   = 8'(HEAD_NODE);
        return 1'b1;
      end
      hdt_pkg::OP_DATA: begin
        if (bytes_left == 0) return 1'b0;
        for (int k = 0; k < 8 && bytes_left != 0; k++) begin
          br = branch_of(cur_node, c.data_byte[k]);
          if (br < hdt_pkg::LITERAL_LIMIT) begin
            bytes_left--;
            cur_node = 8'(HEAD_NODE);
            run[n]   = '{br[7:0], bytes_left == 0, 1'b0, 1'b0};
            n++;
          end else begin
            cur_node = br[7:0];
          end
        end
        if (n > 0) run[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++) pending_symbols.push_back(run[k]);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  function void check_symbol(symbol_t got);
    symbol_t want;
    if (pending_symbols.size() == 0) begin
      $display("%0t: unexpected symbol transaction, expected none, actual %0h",
               $time, got);
      failures++;
      return;
    end
    want = pending_symbols.pop_front();
    compare_field("symbol", want.symbol, got.symbol);
    compare_field("chunk_done", 8'(want.chunk_done), 8'(got.chunk_done));
    compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
    compare_field("load_error", 8'(want.load_error), 8'(got.load_error));
  endfunction

  function int pending_count();
    return pending_symbols.size();
  endfunction
endclass

module tb_huffman_tree_byte_decoder;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hdt_in_if  cmd_if ();
  hdt_out_if sym_if ();

  huffman_tree_byte_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (sym_if)
  );

  symbol_predictor predictor = new();

  int send_idle_pct = 28;
  int recv_idle_pct = 83;
  int stall_cycles  = 0;
  int issued        = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // symbol receiver
  initial begin
    sym_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (stall_cycles > 0) begin
        sym_if.ready <= 1'b0;
        stall_cycles--;
      end else begin
        sym_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk_i);
      if (sym_if.valid && sym_if.ready)
        predictor.check_symbol('{sym_if.symbol, sym_if.chunk_done,
                                 sym_if.run_last, sym_if.load_error});
    end
  end

  function automatic command_t random_command(logic [1:0] op);
    command_t c;
    c.op           = op;
    c.node_index   = 8'($urandom);
    c.child_zero   = 9'($urandom);
    c.child_one    = 9'($urandom);
    c.chunk_length = 24'($urandom);
    c.data_byte    = 8'($urandom);
    return c;
  endfunction

  task automatic send_command(command_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.op           <= c.op;
    cmd_if.node_index   <= c.node_index;
    cmd_if.child_zero   <= c.child_zero;
    cmd_if.child_one    <= c.child_one;
    cmd_if.chunk_length <= c.chunk_length;
    cmd_if.data_byte    <= c.data_byte;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    if (predictor.note_command(c)) issued++;
  endtask

  task automatic send_load(logic [7:0] idx, logic [8:0] c0, logic [8:0] c1);
    command_t c = random_command(hdt_pkg::OP_LOAD);
    c.node_index = idx;
    c.child_zero = c0;
    c.child_one  = c1;
    send_command(c);
  endtask

  task automatic send_start(logic [23:0] len);
    command_t c = random_command(hdt_pkg::OP_START);
    c.chunk_length = len;
    send_command(c);
  endtask

  task automatic send_byte(logic [7:0] data);
    command_t c = random_command(hdt_pkg::OP_DATA);
    c.data_byte = data;
    send_command(c);
  endtask

  task automatic drain_symbols();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (predictor.pending_count() != 0);
  endtask

  function automatic logic [8:0] leaf_or(int kid);
    if (kid >= 0) return 9'(kid);
    if ($urandom_range(11) == 0) return CHILD_OVER;
    return 9'($urandom_range(255));
  endfunction

  // random full tree rooted at the head node
  task automatic send_random_tree();
    logic [7:0] idx_of[40];
    int         kid0[40];
    int         kid1[40];
    bit         taken[256];
    int         n, p, s;
    foreach (taken[j]) taken[j] = 1'b0;
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    idx_of[0] = 8'(HEAD_NODE);
    taken[HEAD_NODE] = 1'b1;
    for (int i = 0; i < n; i++) begin
      kid0[i] = -1;
      kid1[i] = -1;
    end
    for (int i = 1; i < n; i++) begin
      do idx_of[i] = 8'($urandom_range(HEAD_NODE - 1)); while (taken[idx_of[i]]);
      taken[idx_of[i]] = 1'b1;
      do begin
        p = $urandom_range(i - 1);
        s = $urandom_range(1);
      end while ((s != 0 ? kid1[p] : kid0[p]) != -1);
      if (s != 0) kid1[p] = 256 + int'(idx_of[i]);
      else        kid0[p] = 256 + int'(idx_of[i]);
    end
    for (int i = n - 1; i >= 0; i--)
      send_load(idx_of[i], leaf_or(kid0[i]), leaf_or(kid1[i]));
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_command(random_command(OP_RESERVED));
      1: begin
        send_start(24'd0);
        send_byte(8'($urandom));
      end
      2: send_load(NODE_VOID, 9'($urandom), 9'($urandom));
      default: send_load(8'($urandom_range(HEAD_NODE)), 9'($urandom), 9'($urandom));
    endcase
  endtask

  task automatic decode_sequence();
    logic [7:0] data;
    send_random_tree();
    if ($urandom_range(9) == 0) send_start(24'($urandom));
    else                        send_start(24'($urandom_range(1, 30)));
    repeat ($urandom_range(2, 10)) begin
      data = 8'($urandom);
      if (predictor.byte_is_safe(data)) send_byte(data);
    end
  endtask

  task automatic run_random(int target);
    while (issued < target) begin
      if ($urandom_range(99) < 15) send_noise();
      else                         decode_sequence();
    end
  endtask

  initial begin
    cmd_if.valid        <= 1'b0;
    cmd_if.op           <= '0;
    cmd_if.node_index   <= '0;
    cmd_if.child_zero   <= '0;
    cmd_if.child_one    <= '0;
    cmd_if.chunk_length <= '0;
    cmd_if.data_byte    <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: ignored traffic, clamping, out of range node, chunk edges
    send_command(random_command(OP_RESERVED));
    send_byte(8'hff);
    send_load(NODE_VOID, CHILD_OVER, 9'd0);
    send_load(NODE_VOID, 9'd0, 9'd255);
    send_load(8'(HEAD_NODE), hdt_pkg::LITERAL_LIMIT, CHILD_OVER);
    send_load(8'd0, 9'd0, 9'd255);
    send_load(8'd1, hdt_pkg::CHILD_MAX, 9'd256);
    send_start(24'hffffff);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'haa);
    send_start(24'd0);
    send_byte(8'h55);
    send_start(24'd3);
    send_byte(8'h00);
    send_byte(8'h00);
    send_start(24'd5);
    send_byte(8'h01);
    send_byte(8'h02);
    send_start(24'd2);
    send_command(random_command(OP_RESERVED));
    send_byte(8'h02);
    drain_symbols();

    issued = 0;
    run_random(50);
    drain_symbols();

    send_idle_pct = 83;
    recv_idle_pct = 28;
    run_random(100);
    drain_symbols();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles  = 300;
    run_random(150);
    drain_symbols();

    repeat (40) @(posedge clk_i);
    if (predictor.failures == 0 && predictor.pending_count() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hdl/hdt_pkg.sv
hdl/hdt_if.sv
hdl/hdt_ram.sv
hdl/hdt_front.sv
hdl/hdt_fifo.sv
hdl/hdt_back.sv
hdl/huffman_tree_byte_decoder.sv
tb/tb_huffman_tree_byte_decoder.sv
